FILE: rtl/rsbd_pkg.sv
package rsbd_pkg;

  // Bookmark table limit default
  localparam int DEF_MAX_BOOKMARKS = 256;

  // FNV-1a 32 constants
  localparam logic [31:0] HASH_SEED  = 32'd2166136261;
  localparam logic [31:0] HASH_PRIME = 32'd16777619;

  // Shortest complete record, in bytes
  localparam int MIN_RECORD = 42;

  // Results one input byte may cause
  localparam int MAX_RES = 4;
  localparam int CNT_W   = $clog2(MAX_RES + 1);
  localparam int IDX_W   = $clog2(MAX_RES);

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_PAGE_MARGIN  = 3'd0;
  localparam logic [2:0] REG_VIEW_MODE    = 3'd1;
  localparam logic [2:0] REG_SCROLL_SWIPE = 3'd2;
  localparam logic [2:0] REG_MAX_SHARP    = 3'd3;
  localparam logic [2:0] REG_MIN_SHARP    = 3'd4;

  // Result tags
  localparam logic [4:0] TAG_IDENTITY  = 5'd0;
  localparam logic [4:0] TAG_OFFSET    = 5'd1;
  localparam logic [4:0] TAG_BLOCK     = 5'd2;
  localparam logic [4:0] TAG_RELPOS    = 5'd3;
  localparam logic [4:0] TAG_DARK      = 5'd4;
  localparam logic [4:0] TAG_FONT      = 5'd5;
  localparam logic [4:0] TAG_WRAP      = 5'd6;
  localparam logic [4:0] TAG_TABLE     = 5'd7;
  localparam logic [4:0] TAG_GAP       = 5'd8;
  localparam logic [4:0] TAG_MARGIN    = 5'd9;
  localparam logic [4:0] TAG_MODE      = 5'd10;
  localparam logic [4:0] TAG_HEADING   = 5'd11;
  localparam logic [4:0] TAG_COUNT     = 5'd12;
  localparam logic [4:0] TAG_CONTRAST  = 5'd13;
  localparam logic [4:0] TAG_SCROLL    = 5'd14;
  localparam logic [4:0] TAG_SWIPE     = 5'd15;
  localparam logic [4:0] TAG_SHARPNESS = 5'd16;
  localparam logic [4:0] TAG_BOOKMARK  = 5'd17;
  localparam logic [4:0] TAG_STATUS    = 5'd18;

  // Status codes
  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_TRUNCATED = 4'd1;
  localparam logic [3:0] ST_SIGNATURE = 4'd2;
  localparam logic [3:0] ST_VERSION   = 4'd3;
  localparam logic [3:0] ST_MODE      = 4'd4;
  localparam logic [3:0] ST_BOOKMARKS = 4'd5;
  localparam logic [3:0] ST_SHARPNESS = 4'd6;
  localparam logic [3:0] ST_SIZE      = 4'd7;
  localparam logic [3:0] ST_CHECKSUM  = 4'd8;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_record;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  field_tag;
    logic [63:0] field_value;
    logic [7:0]  bookmark_slot;
    logic [3:0]  status_code;
    logic        run_last;
  } out_item_t;

  // All results of one input byte
  typedef struct packed {
    out_item_t [MAX_RES-1:0] res;
    logic [CNT_W-1:0]        cnt;
  } bundle_t;

  typedef struct packed {
    logic [7:0] page_margin;
    logic       view_mode;
    logic [1:0] scroll_swipe;
    logic [3:0] max_sharp;
    logic [3:0] min_sharp;
  } cfg_t;

endpackage

FILE: rtl/reader_state_blob_decoder_core.sv
// Channel   Signals                             Moves
// input     in_valid / in_ready / in_item        one record byte and last flag
// output    out_valid / out_ready / out_item     one tagged field or status
// config    psel penable pwrite paddr pwdata     five registers at 4*index
//
// One byte enters per cycle; the front classifies it in that cycle (one constant
// 32x32 multiply for the hash) and pushes up to four results into a two-entry queue.
// The back emits one result per cycle while out_ready is high; a byte's results hold it.
// Input stalls only when the queue is full; output stalls never block bytes already queued.
// Reset (rst, synchronous) clears the record state, queue and registers to their defaults.
module reader_state_blob_decoder_core import rsbd_pkg::*; #(
  parameter int MAX_BOOKMARKS = DEF_MAX_BOOKMARKS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t    cfg;
  logic    push_valid;
  logic    push_ready;
  bundle_t push_bundle;
  logic    pop_valid;
  logic    pop_ready;
  bundle_t pop_bundle;

  assign pready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.page_margin  <= 8'd0;
      cfg.view_mode    <= 1'b0;
      cfg.scroll_swipe <= 2'd0;
      cfg.max_sharp    <= 4'd4;
      cfg.min_sharp    <= 4'd0;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        REG_PAGE_MARGIN:  cfg.page_margin  <= pwdata[7:0];
        REG_VIEW_MODE:    cfg.view_mode    <= pwdata[0];
        REG_SCROLL_SWIPE: cfg.scroll_swipe <= pwdata[1:0];
        REG_MAX_SHARP:    cfg.max_sharp    <= pwdata[3:0];
        REG_MIN_SHARP:    cfg.min_sharp    <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_PAGE_MARGIN:  prdata = {24'd0, cfg.page_margin};
      REG_VIEW_MODE:    prdata = {31'd0, cfg.view_mode};
      REG_SCROLL_SWIPE: prdata = {30'd0, cfg.scroll_swipe};
      REG_MAX_SHARP:    prdata = {28'd0, cfg.max_sharp};
      REG_MIN_SHARP:    prdata = {28'd0, cfg.min_sharp};
      default:          prdata = 32'd0;
    endcase
  end

  rsbd_front #(.MAX_BOOKMARKS(MAX_BOOKMARKS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_bundle(push_bundle)
  );

  rsbd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_bundle(push_bundle),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_bundle (pop_bundle)
  );

  rsbd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_bundle(pop_bundle),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

FILE: rtl/rsbd_front.sv
module rsbd_front import rsbd_pkg::*; #(
  parameter int MAX_BOOKMARKS = DEF_MAX_BOOKMARKS
) (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  output logic     push_valid,
  input  logic     push_ready,
  output bundle_t  push_bundle
);

  localparam int ENT_W = $clog2(MAX_BOOKMARKS + 1);
  localparam int LW    = $clog2(4 * MAX_BOOKMARKS + 46);
  localparam int CW    = (LW > 13) ? LW : 13;

  logic [11:0]      pos;
  logic [2:0]       ver;
  logic [5:0]       hl;
  logic [63:0]      aw;
  logic [31:0]      hash;
  logic [3:0]       fe;
  logic [ENT_W-1:0] ent;

  logic [2:0]       ver_next;
  logic [5:0]       hl_next;
  logic [3:0]       fe_next;
  logic [ENT_W-1:0] ent_next;
  logic [31:0]      hash_next;
  logic [63:0]      w;
  logic [7:0]       b;
  logic [CW-1:0]    pw;
  logic [CW-1:0]    span;
  logic [CW-1:0]    size;
  logic [CW-1:0]    rel;
  logic [11:0]      base;
  logic [15:0]      ver16;
  logic [15:0]      hs16;
  logic [15:0]      r16;
  logic [6:0]       mask;
  logic [3:0]       sharp;
  logic [3:0]       st;
  logic             skip;
  logic             stop;
  logic             accept;
  logic [CNT_W-1:0] n;
  bundle_t          bund;

  function automatic logic [7:0] sig_byte(input logic [1:0] i);
    case (i)
      2'd0:    sig_byte = 8'h4E;
      2'd1:    sig_byte = 8'h4D;
      2'd2:    sig_byte = 8'h53;
      default: sig_byte = 8'h31;
    endcase
  endfunction

  function automatic logic [7:0] clamp8(input logic [7:0] x, input logic [7:0] lo,
                                        input logic [7:0] hi);
    clamp8 = (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  function automatic out_item_t mk(input logic [4:0] tag, input logic [63:0] val);
    out_item_t o;
    o = '0;
    o.field_tag   = tag;
    o.field_value = val;
    mk = o;
  endfunction

  assign in_ready   = push_ready;
  assign accept     = in_valid && in_ready;
  assign push_valid = in_valid && (n != '0);
  assign push_bundle = bund;

  // Classify one byte: field capture, checks, hash and status
  always_comb begin
    w        = {in_item.data_byte, aw[63:8]};
    b        = in_item.data_byte;
    pw       = CW'(pos);
    span     = CW'(hl) + {ent, 2'b00};
    skip     = in_item.end_of_record && (pos < 12'd41);
    ver_next = ver;
    hl_next  = hl;
    fe_next  = fe;
    ent_next = ent;
    bund     = '0;
    n        = '0;
    stop     = 1'b0;
    ver16    = w[47:32];
    hs16     = w[63:48];
    r16      = w[63:48];
    base     = (ver >= 3'd3) ? 12'd33 : ((ver == 3'd2) ? 12'd32 : 12'd30);
    rel      = pw - CW'(hl);
    mask     = (ver >= 3'd7) ? 7'h7F : (ver == 3'd6) ? 7'h3F : (ver == 3'd5) ? 7'h07 :
               (ver == 3'd4) ? 7'h03 : 7'h01;
    sharp    = cfg.max_sharp;
    size     = pw + CW'(1);
    st       = ST_OK;

    if (!skip && fe == ST_OK) begin
      if (pos < 12'd4) begin
        if (b != sig_byte(pos[1:0])) fe_next = ST_SIGNATURE;
      end else if (pos == 12'd7) begin
        if ((ver16 == 16'd1 && hs16 == 16'd38) || (ver16 == 16'd2 && hs16 == 16'd40) ||
            (ver16 >= 16'd3 && ver16 <= 16'd7 && hs16 == 16'd41)) begin
          ver_next = ver16[2:0];
          hl_next  = hs16[5:0];
        end else begin
          fe_next = ST_VERSION;
        end
      end else if (pos >= 12'd8) begin
        // Fixed-position fields
        if (pos == 12'd15) begin bund.res[n[IDX_W-1:0]] = mk(TAG_IDENTITY, w); n = n + 1'b1; end
        if (pos == 12'd19) begin
          bund.res[n[IDX_W-1:0]] = mk(TAG_OFFSET, {32'd0, w[63:32]}); n = n + 1'b1;
        end
        if (pos == 12'd23) begin
          bund.res[n[IDX_W-1:0]] = mk(TAG_BLOCK, {32'd0, w[63:32]}); n = n + 1'b1;
        end
        if (pos == 12'd25) begin
          bund.res[n[IDX_W-1:0]] = mk(TAG_RELPOS, {48'd0, w[63:48]}); n = n + 1'b1;
        end
        if (pos == 12'd26) begin
          bund.res[n[IDX_W-1:0]] = mk(TAG_DARK, {63'd0, b != 8'd0}); n = n + 1'b1;
        end
        if (pos == 12'd27) begin
          bund.res[n[IDX_W-1:0]] = mk(TAG_FONT, {56'd0, (b < 8'd6) ? 8'd6 : b});
          n = n + 1'b1;
        end
        if (pos == 12'd28) begin
          bund.res[n[IDX_W-1:0]] = mk(TAG_WRAP, {63'd0, b != 8'd0}); n = n + 1'b1;
        end
        if (pos == 12'd29) begin
          bund.res[n[IDX_W-1:0]] = mk(TAG_TABLE, {56'd0, b}); n = n + 1'b1;
          // version 1 defaults
          if (ver == 3'd1) begin
            bund.res[n[IDX_W-1:0]] = mk(TAG_GAP, 64'd4); n = n + 1'b1;
            bund.res[n[IDX_W-1:0]] = mk(TAG_MARGIN,
                                        {56'd0, clamp8(cfg.page_margin, 8'd2, 8'd18)});
            n = n + 1'b1;
            bund.res[n[IDX_W-1:0]] = mk(TAG_MODE, {63'd0, cfg.view_mode});
            n = n + 1'b1;
          end
        end
        if (ver >= 3'd2 && pos == 12'd30) begin
          bund.res[n[IDX_W-1:0]] = mk(TAG_GAP,
                                      {56'd0, (b == 8'd0) ? 8'd0 : clamp8(b, 8'd2, 8'd10)});
          n = n + 1'b1;
        end
        if (ver >= 3'd2 && pos == 12'd31) begin
          bund.res[n[IDX_W-1:0]] = mk(TAG_MARGIN, {56'd0, clamp8(b, 8'd2, 8'd18)});
          n = n + 1'b1;
          if (ver == 3'd2) begin
            bund.res[n[IDX_W-1:0]] = mk(TAG_MODE, {63'd0, cfg.view_mode});
            n = n + 1'b1;
          end
        end
        if (ver >= 3'd3 && pos == 12'd32) begin
          if (b > 8'd1) begin
            fe_next = ST_MODE;
            stop    = 1'b1;
          end else begin
            bund.res[n[IDX_W-1:0]] = mk(TAG_MODE, {56'd0, b}); n = n + 1'b1;
          end
        end
        // Version-dependent tail of the header
        if (!stop && pos == base + 12'd3) begin
          bund.res[n[IDX_W-1:0]] = mk(TAG_HEADING, {32'd0, w[63:32]}); n = n + 1'b1;
        end
        if (!stop && pos == base + 12'd5) begin
          if (17'(r16) > 17'(MAX_BOOKMARKS)) begin
            fe_next = ST_BOOKMARKS;
            stop    = 1'b1;
          end else begin
            ent_next = r16[ENT_W-1:0];
            bund.res[n[IDX_W-1:0]] = mk(TAG_COUNT, {48'd0, r16}); n = n + 1'b1;
          end
        end
        if (!stop && pos == base + 12'd7) begin
          if ((r16 & ~{9'd0, mask}) != 16'd0) begin
            fe_next = ST_BOOKMARKS;
            stop    = 1'b1;
          end else begin
            if (ver >= 3'd6) begin
              sharp = r16[5:2];
              if (sharp > cfg.max_sharp) begin
                fe_next = ST_SHARPNESS;
                stop    = 1'b1;
              end
            end else if (ver == 3'd5) begin
              sharp = r16[2] ? cfg.min_sharp : cfg.max_sharp;
            end
            if (!stop) begin
              bund.res[n[IDX_W-1:0]] = mk(TAG_CONTRAST, {63'd0, r16[0]}); n = n + 1'b1;
              bund.res[n[IDX_W-1:0]] = mk(TAG_SCROLL,
                  {63'd0, (ver >= 3'd4) ? r16[1] : cfg.scroll_swipe[0]});
              n = n + 1'b1;
              bund.res[n[IDX_W-1:0]] = mk(TAG_SWIPE,
                  {63'd0, (ver >= 3'd7) ? r16[6] : cfg.scroll_swipe[1]});
              n = n + 1'b1;
              bund.res[n[IDX_W-1:0]] = mk(TAG_SHARPNESS, {60'd0, sharp}); n = n + 1'b1;
            end
          end
        end
        // Bookmark entries, one per four bytes
        if (!stop && hl != 6'd0 && pw >= CW'(hl) && pw < span && rel[1:0] == 2'd3) begin
          bund.res[n[IDX_W-1:0]] = mk(TAG_BOOKMARK, {32'd0, w[63:32]});
          bund.res[n[IDX_W-1:0]].bookmark_slot = rel[9:2];
          n = n + 1'b1;
        end
      end
    end

    // Checksum covers header and bookmark table
    if (pos < 12'd8 || pw < span) hash_next = (hash ^ {24'd0, b}) * HASH_PRIME;
    else hash_next = hash;

    // Closing status
    if (in_item.end_of_record) begin
      if (size < CW'(MIN_RECORD)) st = ST_TRUNCATED;
      else if (fe_next != ST_OK) st = fe_next;
      else if (size != span + CW'(4)) st = ST_SIZE;
      else if (w[63:32] != hash_next) st = ST_CHECKSUM;
      else st = ST_OK;
      bund.res[n[IDX_W-1:0]] = mk(TAG_STATUS, 64'd0);
      bund.res[n[IDX_W-1:0]].status_code = st;
      bund.res[n[IDX_W-1:0]].run_last = 1'b1;
      n = n + 1'b1;
    end
    bund.cnt = n;
  end

  // Record state
  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      ver  <= '0;
      hl   <= '0;
      aw   <= '0;
      hash <= HASH_SEED;
      fe   <= ST_OK;
      ent  <= '0;
    end else if (accept) begin
      if (in_item.end_of_record) begin
        pos  <= '0;
        ver  <= '0;
        hl   <= '0;
        aw   <= '0;
        hash <= HASH_SEED;
        fe   <= ST_OK;
        ent  <= '0;
      end else begin
        if (pos != 12'd4095) pos <= pos + 12'd1;
        ver  <= ver_next;
        hl   <= hl_next;
        aw   <= w;
        hash <= hash_next;
        fe   <= fe_next;
        ent  <= ent_next;
      end
    end
  end

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    accept && in_item.end_of_record |=> pos == '0 && fe == ST_OK && hash == HASH_SEED)
    else $error("record state not cleared after last byte");
  a_last_pushes: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_item.end_of_record |-> push_valid)
    else $error("last byte without status bundle");
  a_error_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && fe != ST_OK && !in_item.end_of_record |-> !push_valid)
    else $error("results after latched error");

endmodule

FILE: rtl/rsbd_queue.sv
module rsbd_queue import rsbd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push_valid,
  output logic    push_ready,
  input  bundle_t push_bundle,
  output logic    pop_valid,
  input  logic    pop_ready,
  output bundle_t pop_bundle
);

  bundle_t    slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_bundle = slots[rptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Two-entry bundle FIFO
  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= push_bundle;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count out of range");
  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 || count == 2'd2) |-> wptr == rptr)
    else $error("queue pointers disagree with count");
  a_nonempty_bundle: assert property (@(posedge clk) disable iff (rst)
    pop_valid |-> pop_bundle.cnt != '0)
    else $error("empty bundle in queue");

endmodule

FILE: rtl/rsbd_back.sv
module rsbd_back import rsbd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      pop_valid,
  output logic      pop_ready,
  input  bundle_t   pop_bundle,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  bundle_t          cur;
  logic             busy;
  logic [IDX_W-1:0] idx;
  logic             at_end;

  assign at_end    = (CNT_W'(idx) + 1'b1 == cur.cnt);
  assign pop_ready = !busy || (out_ready && at_end);
  assign out_valid = busy;
  assign out_item  = cur.res[idx];

  // Hand out the bundle one result per cycle while out_ready is high
  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) cur <= pop_bundle;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (pop_ready) begin
      busy <= pop_valid;
      idx  <= '0;
    end else if (out_ready) begin
      idx <= idx + 1'b1;
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> CNT_W'(idx) < cur.cnt)
    else $error("result index beyond bundle");
  a_status_ends: assert property (@(posedge clk) disable iff (rst)
    busy && out_item.run_last |-> at_end)
    else $error("status result not last in bundle");
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    busy && !out_ready |=> busy && $stable(idx))
    else $error("result dropped while stalled");

endmodule
